// ===== src/dedup_request_stack_core_assert.svh =====
// Assertion macros shared by the request stack RTL.
// Include after the package import; SYNTH empties every macro.
`ifndef DEDUP_REQUEST_STACK_CORE_ASSERT_SVH
`define DEDUP_REQUEST_STACK_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define DRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("request stack check failed");
// Next-cycle implication, disabled during reset.
`define DRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("request stack check failed");
`else
`define DRS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DRS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/drs_pkg.sv =====
// Shared types and constants for the deduplicating request stack.
// Used by drs_ctrl, drs_dpath and dedup_request_stack_core; no dependencies.
`timescale 1ns / 1ps

package drs_pkg;

   localparam int DEPTH_DEF      = 64;
   localparam int COORD_BITS_DEF = 32;
   localparam int POS_W          = 32;
   localparam int STATUS_W       = 3;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ADDED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MOVED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_POPPED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

   typedef struct packed {
      logic                    func;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic                    check_flag;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [POS_W-1:0] out_x;
      logic signed [POS_W-1:0] out_y;
      logic signed [POS_W-1:0] out_z;
      logic                    out_check;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_INIT,
      S_SHIFT,
      S_PUSH_NEW,
      S_MOVE_TOP,
      S_POP_RD,
      S_POP_OUT
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic                start;
      logic                scan_run;
      logic                shift_init;
      logic                shift_run;
      logic                pop_read;
      logic                post;
      logic [STATUS_W-1:0] post_status;
      logic                wr_new;
      logic                wr_top;
      logic                pop_commit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic fill_zero;
      logic fill_full;
      logic walk_done;
      logic hit;
   } sts_type;

endpackage

// ===== src/dedup_request_stack_core.sv =====
// Deduplicating request stack: LIFO of 3D positions with move-to-top on a repeat push.
// Usage:
//   req_valid/req_stall/req_data carry one push or pop transaction; req_stall is low
//   only while the block is idle, so transactions are handled one at a time.
//   rsp_valid/rsp_stall/rsp_data return exactly one result per transaction.
// Sequence of work per transaction:
//   push, no match : search every entry, then write the new entry on top unless full.
//   push, match at entry m : search every entry, then the entries above m move
//     down one place per cycle through the memory's ports and the entry goes on top.
//   pop : read the top entry, then return it (no read when the stack is empty).
//   The search loop reads one memory entry per cycle.
// Reset empties the stack at once (fill count to zero); no clearing pass is run.
// The result register separates the two sides: a new transaction may be taken while
// a result is held under rsp_stall, but the next result waits until it is taken.
// Depends on drs_pkg, drs_ctrl and drs_dpath.
`timescale 1ns / 1ps

module dedup_request_stack_core import drs_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // Sequencer: take a transaction when idle, walk the search and shift,
   // then hold until the result register is free and post the result.
   drs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: entry memory (one write, one registered read port), fill count,
   // search and shift pointers, match capture and the result register.
   drs_dpath #(
      .DEPTH      (DEPTH),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_data)
   );

endmodule

// ===== src/drs_ctrl.sv =====
// Sequencing state machine of the request stack.
// Depends on drs_pkg; drives drs_dpath through cmd_type, reads sts_type.
`timescale 1ns / 1ps

module drs_ctrl import drs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_func,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = (req_func == FUNC_POP) ? S_POP_RD : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.walk_done) begin
               state_in = sts.hit ? S_SHIFT_INIT : S_PUSH_NEW;
            end
         end
         S_SHIFT_INIT: begin
            cmd.shift_init = 1'b1;
            state_in       = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift_run = 1'b1;
            if (sts.walk_done) begin
               state_in = S_MOVE_TOP;
            end
         end
         S_PUSH_NEW: begin
            if (out_free) begin
               cmd.post = 1'b1;
               if (sts.fill_full) begin
                  cmd.post_status = ST_FULL;
               end else begin
                  cmd.wr_new      = 1'b1;
                  cmd.post_status = ST_ADDED;
               end
               state_in = S_IDLE;
            end
         end
         S_MOVE_TOP: begin
            if (out_free) begin
               cmd.wr_top      = 1'b1;
               cmd.post        = 1'b1;
               cmd.post_status = ST_MOVED;
               state_in        = S_IDLE;
            end
         end
         S_POP_RD: begin
            if (sts.fill_zero) begin
               if (out_free) begin
                  cmd.post        = 1'b1;
                  cmd.post_status = ST_EMPTY;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.pop_read = 1'b1;
               state_in     = S_POP_OUT;
            end
         end
         S_POP_OUT: begin
            if (out_free) begin
               cmd.post        = 1'b1;
               cmd.pop_commit  = 1'b1;
               cmd.post_status = ST_POPPED;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.post || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// ===== src/drs_dpath.sv =====
// Entry memory, fill count, search and shift walkers and result register.
// Depends on drs_pkg and dedup_request_stack_core_assert.svh; driven by drs_ctrl.
`timescale 1ns / 1ps
`include "dedup_request_stack_core_assert.svh"

module drs_dpath import drs_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KEY_W = 3 * COORD_BITS;
   localparam int ENT_W = KEY_W + 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [ENT_W-1:0] mem_ff [DEPTH];
   logic [ENT_W-1:0] rdata_ff;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0] pipe_idx_ff, pipe_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             hit_chk_ff, hit_chk_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             chk_ff, chk_in;
   rsp_type          rsp_ff, rsp_in;

   logic             re, we;
   logic [IDX_W-1:0] raddr, waddr;
   logic [ENT_W-1:0] wdata;

   logic             ptr_live;
   logic [CNT_W-1:0] fill_m1, ptr_m1;
   logic [KEY_W-1:0] rd_key;
   logic             rd_chk;

   // zero-extend or truncate between port and stored coordinate widths
   logic [COORD_BITS+POS_W-1:0] in_x_ext, in_y_ext, in_z_ext;
   logic [COORD_BITS+POS_W-1:0] rd_x_ext, rd_y_ext, rd_z_ext;

   assign in_x_ext = {{COORD_BITS{1'b0}}, req.pos_x};
   assign in_y_ext = {{COORD_BITS{1'b0}}, req.pos_y};
   assign in_z_ext = {{COORD_BITS{1'b0}}, req.pos_z};

   assign rd_key = rdata_ff[ENT_W-1:1];
   assign rd_chk = rdata_ff[0];
   assign rd_x_ext = {{POS_W{1'b0}}, rd_key[KEY_W-1:2*COORD_BITS]};
   assign rd_y_ext = {{POS_W{1'b0}}, rd_key[2*COORD_BITS-1:COORD_BITS]};
   assign rd_z_ext = {{POS_W{1'b0}}, rd_key[COORD_BITS-1:0]};

   assign ptr_live = (ptr_ff < fill_ff);
   assign fill_m1  = fill_ff - 1'b1;
   assign ptr_m1   = ptr_ff - 1'b1;

   always_comb begin
      re          = 1'b0;
      raddr       = ptr_ff[IDX_W-1:0];
      we          = 1'b0;
      waddr       = pipe_idx_ff;
      wdata       = rdata_ff;
      fill_in     = fill_ff;
      ptr_in      = ptr_ff;
      pipe_vld_in = 1'b0;
      pipe_idx_in = pipe_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_chk_in  = hit_chk_ff;
      key_in      = key_ff;
      chk_in      = chk_ff;
      rsp_in      = rsp_ff;

      if (cmd.start) begin
         ptr_in = '0;
         hit_in = 1'b0;
         key_in = {in_x_ext[COORD_BITS-1:0], in_y_ext[COORD_BITS-1:0],
                   in_z_ext[COORD_BITS-1:0]};
         chk_in = req.check_flag;
      end

      // search: read one entry a cycle, compare it the cycle after
      if (cmd.scan_run) begin
         if (ptr_live) begin
            re          = 1'b1;
            ptr_in      = ptr_ff + 1'b1;
            pipe_vld_in = 1'b1;
            pipe_idx_in = ptr_ff[IDX_W-1:0];
         end
         if (pipe_vld_ff && (rd_key == key_ff)) begin
            hit_in     = 1'b1;
            hit_idx_in = pipe_idx_ff;
            hit_chk_in = rd_chk;
         end
      end

      if (cmd.shift_init) begin
         ptr_in = CNT_W'(hit_idx_ff) + CNT_W'(1);
      end

      // close the gap: read entry k, write it to k-1 the cycle after
      if (cmd.shift_run) begin
         if (ptr_live) begin
            re          = 1'b1;
            ptr_in      = ptr_ff + 1'b1;
            pipe_vld_in = 1'b1;
            pipe_idx_in = ptr_m1[IDX_W-1:0];
         end
         if (pipe_vld_ff) begin
            we    = 1'b1;
            waddr = pipe_idx_ff;
            wdata = rdata_ff;
         end
      end

      if (cmd.pop_read) begin
         re    = 1'b1;
         raddr = fill_m1[IDX_W-1:0];
      end

      if (cmd.wr_new) begin
         we      = 1'b1;
         waddr   = fill_ff[IDX_W-1:0];
         wdata   = {key_ff, chk_ff};
         fill_in = fill_ff + 1'b1;
      end

      if (cmd.wr_top) begin
         we    = 1'b1;
         waddr = fill_m1[IDX_W-1:0];
         wdata = {key_ff, chk_ff | hit_chk_ff};
      end

      if (cmd.pop_commit) begin
         fill_in = fill_m1;
      end

      if (cmd.post) begin
         rsp_in        = '0;
         rsp_in.status = cmd.post_status;
         if (cmd.pop_commit) begin
            rsp_in.out_x     = rd_x_ext[POS_W-1:0];
            rsp_in.out_y     = rd_y_ext[POS_W-1:0];
            rsp_in.out_z     = rd_z_ext[POS_W-1:0];
            rsp_in.out_check = rd_chk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         ptr_ff      <= '0;
         pipe_vld_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         ptr_ff      <= ptr_in;
         pipe_vld_ff <= pipe_vld_in;
         hit_ff      <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_idx_ff <= pipe_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_chk_ff  <= hit_chk_in;
      key_ff      <= key_in;
      chk_ff      <= chk_in;
      rsp_ff      <= rsp_in;
   end

   assign sts.fill_zero = (fill_ff == '0);
   assign sts.fill_full = (fill_ff == DEPTH_CNT);
   assign sts.walk_done = !ptr_live && !pipe_vld_ff;
   assign sts.hit       = hit_ff;
   assign rsp           = rsp_ff;

   `DRS_ASSERT_NEXT(a_fill_inc, clock, reset, cmd.wr_new, fill_ff == CNT_W'($past(fill_ff) + 1'b1))
   `DRS_ASSERT_NEXT(a_fill_dec, clock, reset, cmd.pop_commit, fill_ff == CNT_W'($past(fill_ff) - 1'b1))
   `DRS_ASSERT_IMPL(a_no_add_full, clock, reset, cmd.wr_new, !sts.fill_full)
   `DRS_ASSERT_IMPL(a_shift_range, clock, reset, cmd.shift_run && pipe_vld_ff, CNT_W'(pipe_idx_ff) < fill_ff)
   `DRS_ASSERT_IMPL(a_hit_in_scan, clock, reset, $rose(hit_ff), $past(cmd.scan_run))

endmodule
